@@ rtl/vertex_axis_rotate_translate_unit_assert.svh @@
// Assertion macros shared by the vertex transform RTL.
`ifndef VERTEX_AXIS_ROTATE_TRANSLATE_UNIT_ASSERT_SVH
`define VERTEX_AXIS_ROTATE_TRANSLATE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define VART_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define VART_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/vart_pkg.sv @@
// Types, constants and helper functions of the vertex rotate and translate unit.
package vart_pkg;

  localparam int COORD_W   = 32;
  localparam int ANGLE_W   = 16;
  localparam int TURN_W    = 32;
  localparam int TRIG_W    = 32;
  localparam int PROD_W    = COORD_W + TRIG_W;
  localparam int SAT_IN_W  = PROD_W + 1 - 30;
  localparam int ATAN_COUNT = 24;

  localparam int S_TDATA_W = ((ANGLE_W + 6 * COORD_W + 7) / 8) * 8;
  localparam int M_TDATA_W = ((3 * COORD_W + 7) / 8) * 8;
  localparam int S_TUSER_W = 3;

  localparam logic signed [TRIG_W-1:0] TRIG_GAIN = 32'sd652032874;
  localparam logic signed [PROD_W:0]   HALF_LSB  = 65'sd536870912;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_ROTATE    = 1'b1;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_KEEP = 2'd3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic signed [TRIG_W-1:0] x;
    logic signed [TRIG_W-1:0] y;
    logic signed [TRIG_W-1:0] z;
  } trig_t;

  typedef struct packed {
    logic                      keep;
    logic [1:0]                axis;
    logic [1:0]                quad;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] vz;
  } vtx_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [TRIG_W-1:0] atan_step(input int i);
    logic signed [TRIG_W-1:0] a;
    case (i)
      0:       a = 32'sd536870912;
      1:       a = 32'sd316933406;
      2:       a = 32'sd167458907;
      3:       a = 32'sd85004756;
      4:       a = 32'sd42667331;
      5:       a = 32'sd21354465;
      6:       a = 32'sd10679838;
      7:       a = 32'sd5340245;
      8:       a = 32'sd2670163;
      9:       a = 32'sd1335087;
      10:      a = 32'sd667544;
      11:      a = 32'sd333772;
      12:      a = 32'sd166886;
      13:      a = 32'sd83443;
      14:      a = 32'sd41722;
      15:      a = 32'sd20861;
      16:      a = 32'sd10430;
      17:      a = 32'sd5215;
      18:      a = 32'sd2608;
      19:      a = 32'sd1304;
      20:      a = 32'sd652;
      21:      a = 32'sd326;
      22:      a = 32'sd163;
      23:      a = 32'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Clamps a wide signed value to the signed coordinate range.
  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [SAT_IN_W-1:0] v
  );
    logic [SAT_IN_W-COORD_W:0] hi;
    logic signed [COORD_W-1:0] r;
    hi = v[SAT_IN_W-1:COORD_W-1];
    if ((&hi) || !(|hi)) begin
      r = v[COORD_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

@@ rtl/vertex_axis_rotate_translate_unit.sv @@
// Top level of the streaming vertex rotate and translate unit.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  s_axis   | in        | tuser: operation, axis; tdata: angle, offset, vertex
//  m_axis   | out       | tdata: result_x, result_y, result_z
//
// One vertex is accepted per cycle until a stalled output backs up to the
// input; a beat passes from input to output through the entry register, the
// register of each CORDIC cell, and the product and rounding registers.
// Reset clears only the valid bits of the stages; payload registers are free.
// Every stage has its own ready, so a stalled output only holds back items
// once the bubbles in front of it have closed up.
`include "vertex_axis_rotate_translate_unit_assert.svh"

module vertex_axis_rotate_translate_unit #(
  parameter int TRIG_STAGES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: rotation_angle, offset_x, offset_y, offset_z,
  //        vertex_x, vertex_y, vertex_z (from bit 0 up)
  input  logic [vart_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // tuser: operation, axis (from bit 0 up)
  input  logic [vart_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: result_x, result_y, result_z (from bit 0 up)
  output logic [vart_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  localparam int CW = vart_pkg::COORD_W;
  localparam int AW = vart_pkg::ANGLE_W;
  localparam int TW = vart_pkg::TURN_W;
  localparam logic signed [vart_pkg::TRIG_W-1:0] Z_LIMIT = 32'sd536870912;

  // Input field split.
  logic                   operation;
  logic [1:0]             axis;
  logic [AW-1:0]          rotation_angle;
  logic signed [CW-1:0]   offset_x;
  logic signed [CW-1:0]   offset_y;
  logic signed [CW-1:0]   offset_z;
  logic signed [CW-1:0]   vertex_x;
  logic signed [CW-1:0]   vertex_y;
  logic signed [CW-1:0]   vertex_z;

  assign operation      = s_axis_tuser[0];
  assign axis           = s_axis_tuser[2:1];
  assign rotation_angle = s_axis_tdata[AW-1:0];
  assign offset_x       = s_axis_tdata[AW+CW-1:AW];
  assign offset_y       = s_axis_tdata[AW+2*CW-1:AW+CW];
  assign offset_z       = s_axis_tdata[AW+3*CW-1:AW+2*CW];
  assign vertex_x       = s_axis_tdata[AW+4*CW-1:AW+3*CW];
  assign vertex_y       = s_axis_tdata[AW+5*CW-1:AW+4*CW];
  assign vertex_z       = s_axis_tdata[AW+6*CW-1:AW+5*CW];

  // Chain of stages: index 0 is the entry register, 1 .. TRIG_STAGES the cells.
  logic            cv [TRIG_STAGES+1];
  logic            cell_ready [TRIG_STAGES+1];
  vart_pkg::trig_t ct [TRIG_STAGES+1];
  vart_pkg::vtx_t  cx [TRIG_STAGES+1];

  // Entry stage: angle reduction to the nearest quadrant and the translate sums.
  logic [TW-1:0]          turn;
  logic [TW-1:0]          turn_bias;
  logic [1:0]             quad;
  logic [TW-1:0]          residual;
  logic signed [vart_pkg::SAT_IN_W-1:0] sum_x;
  logic signed [vart_pkg::SAT_IN_W-1:0] sum_y;
  logic signed [vart_pkg::SAT_IN_W-1:0] sum_z;
  logic            entry_ready;
  vart_pkg::trig_t entry_trig;
  vart_pkg::vtx_t  entry_vtx;
  logic            head_valid;
  vart_pkg::trig_t head_trig;
  vart_pkg::vtx_t  head_vtx;

  assign turn      = {rotation_angle, {(TW-AW){1'b0}}};
  assign turn_bias = turn + {2'b00, 1'b1, {(TW-3){1'b0}}};
  assign quad      = turn_bias[TW-1:TW-2];
  assign residual  = turn - {quad, {(TW-2){1'b0}}};

  assign sum_x = vart_pkg::SAT_IN_W'(vertex_x) + vart_pkg::SAT_IN_W'(offset_x);
  assign sum_y = vart_pkg::SAT_IN_W'(vertex_y) + vart_pkg::SAT_IN_W'(offset_y);
  assign sum_z = vart_pkg::SAT_IN_W'(vertex_z) + vart_pkg::SAT_IN_W'(offset_z);

  always_comb begin
    entry_trig.x  = vart_pkg::TRIG_GAIN;
    entry_trig.y  = '0;
    entry_trig.z  = residual;
    entry_vtx.axis = axis;
    entry_vtx.quad = quad;
    // Translation and the unused axis code bypass the rotation arithmetic.
    entry_vtx.keep = (operation == vart_pkg::OP_TRANSLATE) || (axis == vart_pkg::AXIS_KEEP);
    if (operation == vart_pkg::OP_TRANSLATE) begin
      entry_vtx.vx = vart_pkg::sat_coord(sum_x);
      entry_vtx.vy = vart_pkg::sat_coord(sum_y);
      entry_vtx.vz = vart_pkg::sat_coord(sum_z);
    end else begin
      entry_vtx.vx = vertex_x;
      entry_vtx.vy = vertex_y;
      entry_vtx.vz = vertex_z;
    end
  end

  assign entry_ready   = !head_valid || cell_ready[0];
  assign s_axis_tready = entry_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else if (entry_ready) begin
      head_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_ready && s_axis_tvalid) begin
      head_trig <= entry_trig;
      head_vtx  <= entry_vtx;
    end
  end

  assign cv[0] = head_valid;
  assign ct[0] = head_trig;
  assign cx[0] = head_vtx;

  // CORDIC chain: cell k shifts by k and hands on a beat each unstalled cycle.
  for (genvar k = 0; k < TRIG_STAGES; k++) begin : g_cell
    vart_cordic_cell #(
      .STAGE(k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (cell_ready[k]),
      .in_trig   (ct[k]),
      .in_vtx    (cx[k]),
      .out_valid (cv[k+1]),
      .out_ready (cell_ready[k+1]),
      .out_trig  (ct[k+1]),
      .out_vtx   (cx[k+1])
    );
  end

  // Products, rounding and saturation; its final register drives m_axis.
  logic signed [CW-1:0] result_x;
  logic signed [CW-1:0] result_y;
  logic signed [CW-1:0] result_z;

  vart_rotate_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[TRIG_STAGES]),
    .in_ready  (cell_ready[TRIG_STAGES]),
    .in_trig   (ct[TRIG_STAGES]),
    .in_vtx    (cx[TRIG_STAGES]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (result_x),
    .out_y     (result_y),
    .out_z     (result_z)
  );

  assign m_axis_tdata = vart_pkg::M_TDATA_W'({result_z, result_y, result_x});

  // Input back-pressure only ever comes from a full, stalled output.
  `VART_ASSERT_IMPL(a_stall_source, !s_axis_tready, m_axis_tvalid && !m_axis_tready,
                    "input stalled without a stalled output")
  // A beat leaving the entry register reaches the first cell.
  `VART_ASSERT_NEXT(a_entry_handoff, cv[0] && cell_ready[0], cv[1],
                    "entry beat lost before the first cell")
  // The reduced angle lies within an eighth of a turn either side of zero.
  `VART_ASSERT_IMPL(a_residual_range, cv[0], (ct[0].z >= -Z_LIMIT) && (ct[0].z < Z_LIMIT),
                    "angle residual outside one eighth of a turn")

endmodule

@@ rtl/vart_cordic_cell.sv @@
// One rotation-mode CORDIC cell of the sine and cosine chain.
module vart_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  vart_pkg::trig_t in_trig,
  input  vart_pkg::vtx_t  in_vtx,
  output logic           out_valid,
  input  logic           out_ready,
  output vart_pkg::trig_t out_trig,
  output vart_pkg::vtx_t  out_vtx
);

  logic                              valid;
  vart_pkg::trig_t                   trig;
  vart_pkg::trig_t                   trig_next;
  vart_pkg::vtx_t                    vtx;
  logic signed [vart_pkg::TRIG_W-1:0] xi;
  logic signed [vart_pkg::TRIG_W-1:0] yi;
  logic signed [vart_pkg::TRIG_W-1:0] zi;
  logic signed [vart_pkg::TRIG_W-1:0] dx;
  logic signed [vart_pkg::TRIG_W-1:0] dy;

  localparam logic signed [vart_pkg::TRIG_W-1:0] ATAN = vart_pkg::atan_step(STAGE);

  assign in_ready = !valid || out_ready;

  assign xi = in_trig.x;
  assign yi = in_trig.y;
  assign zi = in_trig.z;
  assign dx = yi >>> STAGE;
  assign dy = xi >>> STAGE;

  // Turn towards zero residual angle.
  always_comb begin
    if (!zi[vart_pkg::TRIG_W-1]) begin
      trig_next.x = xi - dx;
      trig_next.y = yi + dy;
      trig_next.z = zi - ATAN;
    end else begin
      trig_next.x = xi + dx;
      trig_next.y = yi - dy;
      trig_next.z = zi + ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      trig <= trig_next;
      vtx  <= in_vtx;
    end
  end

  assign out_valid = valid;
  assign out_trig  = trig;
  assign out_vtx   = vtx;

endmodule

@@ rtl/vart_rotate_mac.sv @@
// Quadrant fold, four products, and rounded saturated sums of the rotation.
module vart_rotate_mac (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  vart_pkg::trig_t                    in_trig,
  input  vart_pkg::vtx_t                     in_vtx,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [vart_pkg::COORD_W-1:0] out_x,
  output logic signed [vart_pkg::COORD_W-1:0] out_y,
  output logic signed [vart_pkg::COORD_W-1:0] out_z
);

  logic signed [vart_pkg::TRIG_W-1:0]  tx;
  logic signed [vart_pkg::TRIG_W-1:0]  ty;
  logic signed [vart_pkg::TRIG_W-1:0]  c;
  logic signed [vart_pkg::TRIG_W-1:0]  s;
  logic signed [vart_pkg::TRIG_W-1:0]  sn;
  logic signed [vart_pkg::COORD_W-1:0] u;
  logic signed [vart_pkg::COORD_W-1:0] v;

  logic                                p_valid;
  logic                                p_ready;
  vart_pkg::vtx_t                      p_vtx;
  logic signed [vart_pkg::PROD_W-1:0]  p_uc;
  logic signed [vart_pkg::PROD_W-1:0]  p_vs;
  logic signed [vart_pkg::PROD_W-1:0]  p_us;
  logic signed [vart_pkg::PROD_W-1:0]  p_vc;

  logic                                f_ready;
  logic signed [vart_pkg::PROD_W:0]    first;
  logic signed [vart_pkg::PROD_W:0]    second;
  logic signed [vart_pkg::COORD_W-1:0] r1;
  logic signed [vart_pkg::COORD_W-1:0] r2;
  logic signed [vart_pkg::COORD_W-1:0] x_next;
  logic signed [vart_pkg::COORD_W-1:0] y_next;
  logic signed [vart_pkg::COORD_W-1:0] z_next;

  assign tx = in_trig.x;
  assign ty = in_trig.y;

  // Fold the CORDIC result back into the quadrant taken off the angle.
  always_comb begin
    case (in_vtx.quad)
      vart_pkg::QUAD_0: begin c = tx;  s = ty;  end
      vart_pkg::QUAD_1: begin c = -ty; s = tx;  end
      vart_pkg::QUAD_2: begin c = -tx; s = -ty; end
      vart_pkg::QUAD_3: begin c = ty;  s = -tx; end
      default:          begin c = tx;  s = ty;  end
    endcase
  end

  // The two turned coordinates are u*c - v*sn and u*sn + v*c.
  assign sn = (in_vtx.axis == vart_pkg::AXIS_Y) ? -s : s;
  assign u  = (in_vtx.axis == vart_pkg::AXIS_X) ? in_vtx.vy : in_vtx.vx;
  assign v  = (in_vtx.axis == vart_pkg::AXIS_Z) ? in_vtx.vy : in_vtx.vz;

  assign in_ready = !p_valid || p_ready;
  assign p_ready  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        p_valid <= in_valid;
      end
      if (f_ready) begin
        out_valid <= p_valid;
      end
    end
  end

  assign f_ready = p_ready;

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_vtx <= in_vtx;
      p_uc  <= u * c;
      p_vs  <= v * sn;
      p_us  <= u * sn;
      p_vc  <= v * c;
    end
  end

  assign first  = (vart_pkg::PROD_W + 1)'(p_uc) - (vart_pkg::PROD_W + 1)'(p_vs)
                  + vart_pkg::HALF_LSB;
  assign second = (vart_pkg::PROD_W + 1)'(p_us) + (vart_pkg::PROD_W + 1)'(p_vc)
                  + vart_pkg::HALF_LSB;
  assign r1 = vart_pkg::sat_coord(first[vart_pkg::PROD_W:30]);
  assign r2 = vart_pkg::sat_coord(second[vart_pkg::PROD_W:30]);

  always_comb begin
    x_next = p_vtx.vx;
    y_next = p_vtx.vy;
    z_next = p_vtx.vz;
    if (!p_vtx.keep) begin
      case (p_vtx.axis)
        vart_pkg::AXIS_X: begin y_next = r1; z_next = r2; end
        vart_pkg::AXIS_Y: begin x_next = r1; z_next = r2; end
        vart_pkg::AXIS_Z: begin x_next = r1; y_next = r2; end
        default:          begin end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && p_valid) begin
      out_x <= x_next;
      out_y <= y_next;
      out_z <= z_next;
    end
  end

endmodule

@@ test/tb_vertex_axis_rotate_translate_unit.sv @@
// Self-checking testbench of the streaming vertex rotate and translate unit.
module tb_vertex_axis_rotate_translate_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // The unit is built with its default number of CORDIC cells; the model below follows suit.
  localparam int CORDIC_CELLS = 16;
  // Registers between input and result: entry, CORDIC cells, products and rounded result.
  localparam int PIPE_DEPTH = CORDIC_CELLS + 3;
  // Cycles without any accepted beat after which the run is abandoned.
  localparam int STALL_LIMIT = 4000;
  // Length of the deliberate hold-off on the result side.
  localparam int SINK_HOLD_CYCLES = 80;

  localparam longint CORDIC_START_X = 64'sd652032874;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam longint ARCTAN_TURNS [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  typedef logic signed [vart_pkg::COORD_W-1:0] coord_t;
  typedef logic [vart_pkg::ANGLE_W-1:0]        angle_t;

  // One vertex job as it is offered on the input stream.
  typedef struct {
    logic               op;
    logic [1:0]         axis;
    angle_t             angle;
    coord_t             ox, oy, oz;
    coord_t             vx, vy, vz;
  } vertex_job_t;

  // One transformed vertex as it leaves on the output stream.
  typedef struct {
    coord_t x, y, z;
  } vertex_out_t;

  logic                           clk;
  logic                           rst = 1'b1;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [vart_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [vart_pkg::S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [vart_pkg::M_TDATA_W-1:0] m_axis_tdata;

  vertex_job_t pending_jobs[$];
  vertex_out_t expected_vertices[$];
  vertex_job_t offered_job;

  int  error_count = 0;
  int  result_beats = 0;
  int  quiet_cycles = 0;
  int  hold_left = 0;
  bit  hold_taken = 1'b0;
  // Set by the stimulus sequence to ask for one long hold-off on the result side.
  bit  hold_request = 1'b0;
  // While set, the respective side never idles.
  bit  steady_source = 1'b0;
  bit  steady_sink = 1'b0;

  vertex_axis_rotate_translate_unit #(
    .TRIG_STAGES(CORDIC_CELLS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Clamps a wide signed value to the signed coordinate range.
  function automatic coord_t clamp_coord(input logic signed [79:0] v);
    coord_t r;
    if (v > 80'sd2147483647) begin
      r = {1'b0, {(vart_pkg::COORD_W-1){1'b1}}};
    end else if (v < -80'sd2147483648) begin
      r = {1'b1, {(vart_pkg::COORD_W-1){1'b0}}};
    end else begin
      r = v[vart_pkg::COORD_W-1:0];
    end
    return r;
  endfunction

  // Cosine and sine in Q2.30 from the quadrant-reduced rotation-mode CORDIC.
  function automatic void cordic_cos_sin(input angle_t angle,
                                         output longint c, output longint s);
    logic [31:0] turn;
    logic [31:0] shifted;
    logic [31:0] residual;
    logic [1:0]  quad;
    longint      x, y, z, dx, dy;
    turn     = {angle, {(32-vart_pkg::ANGLE_W){1'b0}}};
    shifted  = turn + 32'h2000_0000;
    quad     = shifted[31:30];
    residual = turn - {quad, 30'd0};
    z = longint'(signed'(residual));
    x = CORDIC_START_X;
    y = 0;
    for (int i = 0; i < CORDIC_CELLS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ARCTAN_TURNS[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ARCTAN_TURNS[i];
      end
    end
    case (quad)
      vart_pkg::QUAD_0: begin
        c = x;
        s = y;
      end
      vart_pkg::QUAD_1: begin
        c = -y;
        s = x;
      end
      vart_pkg::QUAD_2: begin
        c = -x;
        s = -y;
      end
      default: begin
        c = y;
        s = -x;
      end
    endcase
  endfunction

  // a*ta + b*tb in Q2.30 terms, rounded half up to a whole coordinate and clamped.
  function automatic coord_t mix_pair(input coord_t a, input longint ta,
                                      input coord_t b, input longint tb);
    longint                la, lb;
    logic signed [79:0]    acc;
    la  = a;
    lb  = b;
    acc = la * ta + lb * tb + 80'sd536870912;
    return clamp_coord(acc >>> 30);
  endfunction

  function automatic coord_t add_coord(input coord_t a, input coord_t b);
    logic signed [79:0] acc;
    acc = a;
    acc = acc + b;
    return clamp_coord(acc);
  endfunction

  // Expected output of the unit for one job.
  function automatic vertex_out_t predict_vertex(input vertex_job_t j);
    vertex_out_t r;
    longint      c, s;
    r.x = j.vx;
    r.y = j.vy;
    r.z = j.vz;
    if (j.op == vart_pkg::OP_TRANSLATE) begin
      r.x = add_coord(j.vx, j.ox);
      r.y = add_coord(j.vy, j.oy);
      r.z = add_coord(j.vz, j.oz);
    end else begin
      cordic_cos_sin(j.angle, c, s);
      case (j.axis)
        vart_pkg::AXIS_X: begin
          r.y = mix_pair(j.vy, c, j.vz, -s);
          r.z = mix_pair(j.vy, s, j.vz, c);
        end
        vart_pkg::AXIS_Y: begin
          r.x = mix_pair(j.vx, c, j.vz, s);
          r.z = mix_pair(j.vx, -s, j.vz, c);
        end
        vart_pkg::AXIS_Z: begin
          r.x = mix_pair(j.vx, c, j.vy, -s);
          r.y = mix_pair(j.vx, s, j.vy, c);
        end
        default: begin
          // The spare axis code leaves the vertex as it came in.
        end
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input int beat, input string what,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("mismatch on result beat %0d, %s: got %h, want %h", beat, what, got, want);
    error_count++;
  endtask

  task automatic push_job(input logic op, input logic [1:0] axis,
                          input angle_t angle,
                          input coord_t ox, input coord_t oy, input coord_t oz,
                          input coord_t vx, input coord_t vy, input coord_t vz);
    vertex_job_t j;
    j.op    = op;
    j.axis  = axis;
    j.angle = angle;
    j.ox    = ox;
    j.oy    = oy;
    j.oz    = oz;
    j.vx    = vx;
    j.vy    = vy;
    j.vz    = vz;
    pending_jobs.push_back(j);
  endtask

  // Coordinates lean towards the extremes and small values so that both clamping and
  // the fine rounding of the products are exercised.
  function automatic coord_t pick_coord();
    coord_t v;
    case ($urandom_range(9))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = $urandom_range(32'h0020_0000) - 32'h0010_0000;
      3:       v = $urandom_range(32'h0400_0000) - 32'h0200_0000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Angles near the quadrant boundaries decide the reduction; the rest are uniform.
  function automatic angle_t pick_angle();
    angle_t a;
    if ($urandom_range(1) == 0) begin
      a = angle_t'($urandom_range(16'hFFFF));
    end else begin
      a = {3'($urandom_range(7)), 13'd0};
      a = a + angle_t'($urandom_range(4)) - angle_t'(2);
    end
    return a;
  endfunction

  task automatic push_random_jobs(input int count);
    for (int n = 0; n < count; n++) begin
      push_job(($urandom_range(1) == 0) ? vart_pkg::OP_TRANSLATE : vart_pkg::OP_ROTATE,
               ($urandom_range(15) == 0) ? vart_pkg::AXIS_KEEP : 2'($urandom_range(2)),
               pick_angle(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), pick_coord());
    end
  endtask

  // Holds the stimulus back until every job has been accepted and every result seen.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_jobs.size() != 0 || s_axis_tvalid || expected_vertices.size() != 0);
  endtask

  // Source side: offers the queued jobs, one beat per handshake, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_vertices.push_back(predict_vertex(offered_job));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_jobs.size() != 0 && (steady_source || $urandom_range(99) >= 11)) begin
          offered_job = pending_jobs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= vart_pkg::S_TDATA_W'({offered_job.vz, offered_job.vy,
                                                 offered_job.vx, offered_job.oz,
                                                 offered_job.oy, offered_job.ox,
                                                 offered_job.angle});
          s_axis_tuser  <= {offered_job.axis, offered_job.op};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: checks every accepted beat against the oldest prediction and drives
  // tready with random gaps and one long hold-off.
  always @(posedge clk) begin
    vertex_out_t want;
    coord_t      got_x, got_y, got_z;
    if (m_axis_tvalid && m_axis_tready) begin
      got_x = m_axis_tdata[vart_pkg::COORD_W-1:0];
      got_y = m_axis_tdata[2*vart_pkg::COORD_W-1:vart_pkg::COORD_W];
      got_z = m_axis_tdata[3*vart_pkg::COORD_W-1:2*vart_pkg::COORD_W];
      if (expected_vertices.size() == 0) begin
        report_mismatch(result_beats, "beat with nothing outstanding, result_x", got_x, '0);
      end else begin
        want = expected_vertices.pop_front();
        if (got_x !== want.x) report_mismatch(result_beats, "result_x", got_x, want.x);
        if (got_y !== want.y) report_mismatch(result_beats, "result_y", got_y, want.y);
        if (got_z !== want.z) report_mismatch(result_beats, "result_z", got_z, want.z);
      end
      result_beats++;
    end
    if (hold_request && !hold_taken) begin
      hold_left  = SINK_HOLD_CYCLES;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady_sink || ($urandom_range(99) >= 11);
    end
  end

  // Watchdog: a run in which no beat moves on either side for too long has hung.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed jobs: clamping of sums, each axis at the quarter turns and at the
    // quadrant rounding boundary, the spare axis code and ignored fields.
    push_job(vart_pkg::OP_TRANSLATE, vart_pkg::AXIS_X, '0,
             32'h7FFF_FFFF, 32'h8000_0000, 32'd0,
             32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    push_job(vart_pkg::OP_TRANSLATE, vart_pkg::AXIS_KEEP, 16'hFFFF,
             32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000,
             32'h0002_8000, 32'h0000_0001, 32'hFFFF_FFFF);
    push_job(vart_pkg::OP_TRANSLATE, vart_pkg::AXIS_Z, 16'h1234,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
    for (logic [1:0] ax = vart_pkg::AXIS_X; ax <= vart_pkg::AXIS_Z; ax++) begin
      push_job(vart_pkg::OP_ROTATE, ax, 16'h0000, 32'h1111_1111, '0, '0,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      push_job(vart_pkg::OP_ROTATE, ax, 16'h4000, '0, '0, '0,
               32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      push_job(vart_pkg::OP_ROTATE, ax, 16'h8000, '0, '0, '0,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_job(vart_pkg::OP_ROTATE, ax, 16'h2000, '0, '0, '0,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      push_job(vart_pkg::OP_ROTATE, ax, 16'hE000, '0, '0, '0,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      push_job(vart_pkg::OP_ROTATE, ax, 16'hFFFF, '0, '0, '0,
               32'hFFFF_8000, 32'h0000_7FFF, 32'hFFFE_0001);
    end
    push_job(vart_pkg::OP_ROTATE, vart_pkg::AXIS_KEEP, 16'h4000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
    push_job(vart_pkg::OP_ROTATE, vart_pkg::AXIS_Z, 16'hC000,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    push_job(vart_pkg::OP_ROTATE, vart_pkg::AXIS_Y, 16'h5FFF, '0, '0, '0,
             32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // The source pauses here until every directed result has come back.
    wait_drained();

    // Random jobs with gaps on both sides.
    push_random_jobs(130);
    wait_drained();

    // The result side holds off for a long stretch while the source keeps offering
    // beats, so the pipeline fills up and the input stalls.
    steady_source = 1'b1;
    push_random_jobs(100);
    hold_request = 1'b1;
    wait_drained();
    steady_source = 1'b0;

    // A long stretch with no idling on either side.
    steady_source = 1'b1;
    steady_sink   = 1'b1;
    push_random_jobs(150);
    wait_drained();
    steady_source = 1'b0;
    steady_sink   = 1'b0;

    // Any stray beat after the last expected one would show up in this window.
    repeat (PIPE_DEPTH + 20) @(negedge clk);
    if (expected_vertices.size() != 0) begin
      report_mismatch(result_beats, "results still outstanding, count",
                      32'(expected_vertices.size()), '0);
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/vart_pkg.sv
rtl/vart_cordic_cell.sv
rtl/vart_rotate_mac.sv
rtl/vertex_axis_rotate_translate_unit.sv
test/tb_vertex_axis_rotate_translate_unit.sv
